FILE: rtl/ifm_pkg.sv
package ifm_pkg;

    typedef struct packed {
        logic [31:0] bottom_sample;
        logic        last_of_set;
    } t_in;

    typedef struct packed {
        logic [31:0] min_sample;
        logic [1:0]  status;
    } t_out;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_UPD,
        S_DIFF,
        S_TRIPLE,
        S_RHS,
        S_MSCAN,
        S_MWAIT,
        S_DONE
    } t_state;

    // control group from the sequencer to the radix selector
    typedef struct packed {
        logic init;
        logic dv;
        logic upd;
    } t_sel_ctl;

endpackage

FILE: rtl/ifm_mem.sv
module ifm_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/ifm_select.sv
// Radix selection of three order statistics at once, one bit per pass.
module ifm_select #(
    parameter int CW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ifm_pkg::t_sel_ctl i_ctl,
    input  logic [CW-1:0]     i_k [3],
    input  logic [31:0]       i_data,
    output logic [31:0]       o_q [3],
    output logic              o_last_bit
);

    logic [CW-1:0] r_k [3];
    logic [CW-1:0] r_c [3];
    logic [31:0]   r_p [3];
    logic [31:0]   r_mask;
    logic [31:0]   r_bsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsel <= 32'h8000_0000;
            r_mask <= '0;
        end else if (i_ctl.init) begin
            r_bsel <= 32'h8000_0000;
            r_mask <= '0;
        end else if (i_ctl.upd) begin
            r_bsel <= {1'b0, r_bsel[31:1]};
            r_mask <= {1'b1, r_mask[31:1]};
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_q
        logic w_match;
        assign w_match = (((i_data ^ r_p[j]) & r_mask) == '0) && ((i_data & r_bsel) == '0);

        always_ff @(posedge i_clk) begin
            if (i_ctl.init) begin
                r_k[j] <= i_k[j];
                r_p[j] <= '0;
                r_c[j] <= '0;
            end else if (i_ctl.upd) begin
                if (r_k[j] >= r_c[j]) begin
                    r_p[j] <= r_p[j] | r_bsel;
                    r_k[j] <= r_k[j] - r_c[j];
                end
                r_c[j] <= '0;
            end else if (i_ctl.dv && w_match) begin
                r_c[j] <= r_c[j] + 1'b1;
            end
        end

        assign o_q[j] = r_p[j];
    end

    assign o_last_bit = r_bsel[0];

endmodule

FILE: rtl/iqr_filtered_minimum.sv
// Channel  | Valid       | Stall        | Payload
// input    | i_in_valid  | o_in_stall   | i_in_data  (ifm_pkg::t_in)
// output   | o_out_valid | i_out_stall  | o_out_data (ifm_pkg::t_out)
//
// Loading accepts a transaction whenever the sequencer is idle. A closing transaction of n > 1 values runs
// 32 radix passes (each a scan, a wait and an update step, one memory read port), the threshold
// steps S_DIFF, S_TRIPLE and S_RHS, a minimum pass and a hand-off; n = 1 or overflow goes straight to hand-off.
// Synchronous active-low reset clears count, overflow flag, sequencer and valid.
// The result waits in an output register; input is stalled while a set is evaluated
// and while a finished result waits for the output register to free up.
module iqr_filtered_minimum #(
    parameter int MAX_BEAMS = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ifm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ifm_pkg::t_out o_out_data
);

    localparam int CW = $clog2(MAX_BEAMS + 1);
    localparam int AW = (MAX_BEAMS > 1) ? $clog2(MAX_BEAMS) : 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BEAMS);

    ifm_pkg::t_state   r_state, n_state;
    ifm_pkg::t_sel_ctl w_ctl;
    ifm_pkg::t_out     r_res, r_out;

    logic [CW-1:0]        r_cnt, r_n, r_idx;
    logic                 r_ovf, r_dv, r_out_valid;
    logic [31:0]          r_best, r_d;
    logic                 r_found;
    logic [33:0]          r_d3;
    logic signed [35:0]   r_rhs;
    logic [31:0]          w_rdata;
    logic [31:0]          w_q [3];
    logic [CW-1:0]        w_k [3];
    logic                 w_last_bit, w_in_acc, w_full, w_out_free;
    logic [CW-1:0]        w_n;
    logic [CW+1:0]        w_n3;
    logic                 w_pass;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_cnt == MAX_CNT);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_n        = r_cnt + 1'b1;
    assign w_n3       = {2'b0, w_n} + {1'b0, w_n, 1'b0};
    assign w_k[0]     = w_n >> 2;
    assign w_k[1]     = w_n >> 1;
    assign w_k[2]     = w_n3[CW+1:2];
    assign w_pass     = ($signed({3'b0, w_rdata, 1'b0}) > r_rhs) && (w_rdata < r_best);

    ifm_mem #(.DEPTH(MAX_BEAMS), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !w_full),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_in_data.bottom_sample),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    ifm_select #(.CW(CW)) u_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_k        (w_k),
        .i_data     (w_rdata),
        .o_q        (w_q),
        .o_last_bit (w_last_bit)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ifm_pkg::S_IDLE: begin
                if (w_in_acc && i_in_data.last_of_set) begin
                    if (r_ovf || w_full || r_cnt == '0) n_state = ifm_pkg::S_DONE;
                    else n_state = ifm_pkg::S_SCAN;
                end
            end
            ifm_pkg::S_SCAN:   if (r_idx == r_n - 1'b1) n_state = ifm_pkg::S_WAIT;
            ifm_pkg::S_WAIT:   n_state = ifm_pkg::S_UPD;
            ifm_pkg::S_UPD: begin
                n_state = w_last_bit ? ifm_pkg::S_DIFF : ifm_pkg::S_SCAN;
            end
            ifm_pkg::S_DIFF:   n_state = ifm_pkg::S_TRIPLE;
            ifm_pkg::S_TRIPLE: n_state = ifm_pkg::S_RHS;
            ifm_pkg::S_RHS:    n_state = ifm_pkg::S_MSCAN;
            ifm_pkg::S_MSCAN:  if (r_idx == r_n - 1'b1) n_state = ifm_pkg::S_MWAIT;
            ifm_pkg::S_MWAIT:  n_state = ifm_pkg::S_DONE;
            ifm_pkg::S_DONE:   if (w_out_free) n_state = ifm_pkg::S_IDLE;
            default:           n_state = ifm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ifm_pkg::S_IDLE);
        w_ctl.init = (r_state == ifm_pkg::S_IDLE);
        w_ctl.upd  = (r_state == ifm_pkg::S_UPD);
        w_ctl.dv   = r_dv && (r_state == ifm_pkg::S_SCAN || r_state == ifm_pkg::S_WAIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ifm_pkg::S_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == ifm_pkg::S_SCAN) || (r_state == ifm_pkg::S_MSCAN);
            if (w_in_acc) begin
                if (i_in_data.last_of_set) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_cnt <= w_n;
                end
            end
            if (r_state == ifm_pkg::S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ifm_pkg::S_IDLE: begin
                r_idx <= '0;
                if (w_in_acc && i_in_data.last_of_set) begin
                    r_n <= w_n;
                    if (r_ovf || w_full) begin
                        r_res <= '{min_sample: '0, status: ifm_pkg::ST_OVER};
                    end else begin
                        r_res <= '{min_sample: i_in_data.bottom_sample,
                                   status: ifm_pkg::ST_OK};
                    end
                end
            end
            ifm_pkg::S_SCAN, ifm_pkg::S_MSCAN: r_idx <= r_idx + 1'b1;
            ifm_pkg::S_UPD:    r_idx <= '0;
            ifm_pkg::S_DIFF:   r_d   <= w_q[2] - w_q[0];
            ifm_pkg::S_TRIPLE: r_d3  <= {2'b0, r_d} + {1'b0, r_d, 1'b0};
            ifm_pkg::S_RHS: begin
                r_rhs   <= $signed({3'b0, w_q[1], 1'b0}) - $signed({2'b0, r_d3});
                r_best  <= ifm_pkg::ALL_ONES;
                r_found <= 1'b0;
                r_idx   <= '0;
            end
            ifm_pkg::S_MWAIT: begin
                if (r_dv && w_pass) begin
                    r_res <= '{min_sample: w_rdata, status: ifm_pkg::ST_OK};
                end else if (r_found) begin
                    r_res <= '{min_sample: r_best, status: ifm_pkg::ST_OK};
                end else begin
                    r_res <= '{min_sample: '0, status: ifm_pkg::ST_NONE};
                end
            end
            default: ;
        endcase
        if (r_state == ifm_pkg::S_MSCAN && r_dv && w_pass) begin
            r_best  <= w_rdata;
            r_found <= 1'b1;
        end
        if (r_state == ifm_pkg::S_DONE && w_out_free) r_out <= r_res;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ifm_pkg::S_IDLE) |-> o_in_stall)
        else $error("input taken while evaluating");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.last_of_set) |=> (r_state != ifm_pkg::S_IDLE))
        else $error("closing transaction produced no evaluation");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("bad status code");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("count beyond store");
    a_nonzero_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ifm_pkg::ST_OK) |-> (o_out_data.min_sample == '0))
        else $error("error result carries a sample");

endmodule

FILE: bench/tb_iqr_filtered_minimum.sv
`timescale 1ns / 1ps

module tb_iqr_filtered_minimum;

    localparam int MAX_BEAMS  = 512;
    localparam int WDOG_LIMIT = 200000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    ifm_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    ifm_pkg::t_out  o_out_data;

    iqr_filtered_minimum #(.MAX_BEAMS(MAX_BEAMS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // predictor state
    logic [31:0]    beam_vals[MAX_BEAMS];
    int             beam_cnt;
    bit             beam_over;
    ifm_pkg::t_out  minimum_q[$];

    int  errors;
    int  in_pct, out_pct;
    bit  hold_off;
    int  n_in, n_out, n_none, n_over;
    int  idle_cycles;

    // directed table; want_chk set where the result is typed in
    typedef struct {
        logic [31:0]    smp;
        logic           lst;
        bit             want_chk;
        ifm_pkg::t_out  want;
    } t_row;
    t_row dir_tab[$];

    function automatic ifm_pkg::t_out predict_minimum(logic [31:0] smp, logic lst);
        ifm_pkg::t_out r;
        logic [31:0] srt[$];
        logic [31:0] q1, med, q3, best;
        longint rhs;
        bit found;
        int n;
        r = '0;
        if (beam_cnt < MAX_BEAMS) begin
            beam_vals[beam_cnt] = smp;
            beam_cnt++;
        end else begin
            beam_over = 1'b1;
        end
        if (!lst) return r;
        n = beam_cnt;
        if (beam_over || n == 0) begin
            r.status = ifm_pkg::ST_OVER;
        end else if (n == 1) begin
            r.min_sample = beam_vals[0];
            r.status = ifm_pkg::ST_OK;
        end else begin
            for (int i = 0; i < n; i++) srt.push_back(beam_vals[i]);
            srt.sort();
            q1 = srt[n/4]; med = srt[n/2]; q3 = srt[(3*n)/4];
            rhs = 2 * longint'(med) - 3 * (longint'(q3) - longint'(q1));
            best = ifm_pkg::ALL_ONES; found = 0;
            for (int i = 0; i < n; i++)
                if (2 * longint'(beam_vals[i]) > rhs && beam_vals[i] < best) begin
                    best = beam_vals[i]; found = 1;
                end
            if (found) begin
                r.min_sample = best; r.status = ifm_pkg::ST_OK;
            end else begin
                r.status = ifm_pkg::ST_NONE;
            end
        end
        beam_cnt = 0;
        beam_over = 0;
        return r;
    endfunction

    // one transaction on the input channel; starts and ends at a falling edge
    task automatic send_beam(logic [31:0] smp, logic lst);
        while ($urandom_range(99) < in_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{bottom_sample: smp, last_of_set: lst};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (lst) minimum_q.push_back(predict_minimum(smp, lst));
        else void'(predict_minimum(smp, lst));
        n_in++;
        @(negedge i_clk);
    endtask

    task automatic add_row(logic [31:0] s, logic l, bit c = 0, ifm_pkg::t_out w = '0);
        dir_tab.push_back('{smp: s, lst: l, want_chk: c, want: w});
    endtask

    // random set: mostly plausible ping profiles, some wild values
    task automatic send_set(int n);
        logic [31:0] base, v;
        int mode;
        base = $urandom;
        mode = $urandom_range(3);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: v = $urandom;
                1: v = base + $urandom_range(200);
                2: v = ($urandom_range(9) == 0) ? $urandom
                                                : (base & 32'h00FF_FFFF) + $urandom_range(50);
                default: v = ($urandom_range(3) == 0) ? ifm_pkg::ALL_ONES : $urandom_range(4);
            endcase
            send_beam(v, i == n - 1);
        end
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (hold_off) i_out_stall <= 1'b1;
        else i_out_stall <= ($urandom_range(99) < out_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (minimum_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_out_data);
                errors++;
            end else begin
                ifm_pkg::t_out w;
                w = minimum_q.pop_front();
                if (w.min_sample !== o_out_data.min_sample)
                    begin
                    $display("%0t: min_sample expected %h actual %h",
                             $time, w.min_sample, o_out_data.min_sample);
                    errors++;
                end
                if (w.status !== o_out_data.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, w.status, o_out_data.status);
                    errors++;
                end
                if (w.status == ifm_pkg::ST_NONE) n_none++;
                if (w.status == ifm_pkg::ST_OVER) n_over++;
            end
            n_out++;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired at %0t", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    // directed results checked against typed-in values through the queue
    task automatic run_table();
        foreach (dir_tab[k]) begin
            send_beam(dir_tab[k].smp, dir_tab[k].lst);
            if (dir_tab[k].want_chk && dir_tab[k].lst) begin
                if (minimum_q[$] !== dir_tab[k].want) begin
                    $display("%0t: table row %0d expected %h actual %h",
                             $time, k, dir_tab[k].want, minimum_q[$]);
                    errors++;
                end
            end
        end
    endtask

    initial begin
        errors = 0; n_in = 0; n_out = 0; n_none = 0; n_over = 0;
        beam_cnt = 0; beam_over = 0; idle_cycles = 0;
        hold_off = 0; in_pct = 36; out_pct = 63;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in_data = '0; i_out_stall = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single values, extremes
        add_row(32'h0, 1, 1, '{min_sample: 32'h0, status: ifm_pkg::ST_OK});
        add_row(ifm_pkg::ALL_ONES, 1, 1,
                '{min_sample: ifm_pkg::ALL_ONES, status: ifm_pkg::ST_OK});
        // only all-ones values; none passes
        add_row(ifm_pkg::ALL_ONES, 0);
        add_row(ifm_pkg::ALL_ONES, 1, 1, '{min_sample: 32'h0, status: ifm_pkg::ST_NONE});
        // two extremes
        add_row(32'h0, 0); add_row(ifm_pkg::ALL_ONES, 1);
        // outlier below threshold rejected
        add_row(32'd1, 0); add_row(32'd1000, 0); add_row(32'd1001, 0);
        add_row(32'd1002, 0); add_row(32'd1003, 1);
        // equal values, strict comparison
        add_row(32'd7, 0); add_row(32'd7, 0); add_row(32'd7, 1);
        // alternating bits
        add_row(32'hAAAA_AAAA, 0); add_row(32'h5555_5555, 0); add_row(32'h8000_0000, 1);
        add_row(32'h0000_0001, 0); add_row(ifm_pkg::ALL_ONES, 0);
        add_row(ifm_pkg::ALL_ONES, 1);
        run_table();

        // overflow sets, closing item also dropped
        for (int i = 0; i < MAX_BEAMS; i++) send_beam($urandom, 1'b0);
        send_beam(32'h1234_5678, 1'b1);
        for (int i = 0; i < MAX_BEAMS + 3; i++) send_beam($urandom, i == MAX_BEAMS + 2);
        // full store exactly
        send_set(MAX_BEAMS);

        // long receiver hold-off while sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (3000) @(posedge i_clk);
                hold_off = 0;
            end
            begin
                for (int s = 0; s < 8; s++) send_set($urandom_range(1, 6));
                i_in_valid <= 1'b0;
            end
        join
        @(negedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            in_pct  = (ph == 0) ? 36 : (ph == 1) ? 63 : 0;
            out_pct = (ph == 0) ? 63 : (ph == 1) ? 36 : 0;
            for (int c = 0; c < 30; c++)
                send_set(($urandom_range(19) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 4));
        end
        i_in_valid <= 1'b0;

        while (minimum_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Sent %0d beam values, checked %0d set results", n_in, n_out);
        $display("(%0d with no valid sample, %0d overflowed).", n_none, n_over);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
